// File: rtl/core/first_fit_slice_time_reserver_unit_assert.svh
// Assertion macros used by the slice/time reserver search engine.
`ifndef FIRST_FIT_SLICE_TIME_RESERVER_UNIT_ASSERT_SVH
`define FIRST_FIT_SLICE_TIME_RESERVER_UNIT_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication check.
`define FFSTR_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ffstr same-cycle check failed");
// Next-cycle implication check.
`define FFSTR_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ffstr next-cycle check failed");
`else
`define FFSTR_ASSERT_IMP(label, clk, rst, ante, cons)
`define FFSTR_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/core/ffstr_pkg.sv
// Shared constants and types for the first-fit slice/time reserver.
`default_nettype none
package ffstr_pkg;
  localparam int MAX_SLICES = 64;
  localparam int HORIZON    = 4096;
  localparam int SLICE_W    = 7;
  localparam int ROW_W      = $clog2(HORIZON);
  localparam int TIME_W     = ROW_W + 1;
  localparam int SUM_W      = TIME_W + 1;
  localparam int DUR_W      = 13;
  localparam int START_W    = 12;

  localparam logic [SUM_W-1:0]   HORIZON_S = SUM_W'(HORIZON);
  localparam logic [SLICE_W-1:0] MAX_SL    = SLICE_W'(MAX_SLICES);

  // Request handed from the front end to the search engine.
  typedef struct packed {
    logic               valid;
    logic [TIME_W-1:0]  level_start;
    logic [SLICE_W-1:0] need;
    logic [DUR_W-1:0]   dur;
    logic [SLICE_W-1:0] usable;
  } ffstr_req_t;

  // Result handed back from the search engine.
  typedef struct packed {
    logic               valid;
    logic               placed;
    logic [START_W-1:0] grant_time;
    logic [SLICE_W-1:0] first_slice;
    logic [TIME_W-1:0]  end_step;
  } ffstr_res_t;
endpackage
`default_nettype wire

// File: rtl/core/ffstr_engine.sv
// Search engine: occupancy grid memory and the first-fit search sequencer.
`default_nettype none
module ffstr_engine (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ffstr_pkg::ffstr_req_t req,
  output logic                   req_ready,
  output ffstr_pkg::ffstr_res_t  res,
  input  wire logic              res_take
);
  import ffstr_pkg::*;
  `include "first_fit_slice_time_reserver_unit_assert.svh"

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_TCHK  = 7'b0000100,
    ST_READ  = 7'b0001000,
    ST_SCAN  = 7'b0010000,
    ST_MARK  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } st_t;

  st_t st;
  logic [ROW_W-1:0]      clr_addr;
  logic [TIME_W-1:0]     t;
  logic [DUR_W-1:0]      k;
  logic [SLICE_W-1:0]    need;
  logic [DUR_W-1:0]      dur;
  logic [SLICE_W-1:0]    usable;
  logic [SLICE_W-1:0]    s;
  logic [MAX_SLICES-1:0] busy;
  logic [MAX_SLICES-1:0] mask;
  logic                  rd_vld;
  logic [MAX_SLICES-1:0] rdata;
  logic [ROW_W-1:0]      rd_addr_q;
  logic                  res_placed;
  logic [START_W-1:0]    res_start;
  logic [SLICE_W-1:0]    res_slice;
  logic [TIME_W-1:0]     res_end;

  logic [MAX_SLICES-1:0] mem [HORIZON];

  logic                  rd_en;
  logic [ROW_W-1:0]      raddr;
  logic                  mem_we;
  logic [ROW_W-1:0]      waddr;
  logic [MAX_SLICES-1:0] wdata;
  logic                  req_bad;
  logic [SUM_W-1:0]      t_end;
  logic [SUM_W-1:0]      s_end;
  logic [MAX_SLICES-1:0] base_mask;
  logic [TIME_W-1:0]     row_sum;
  logic                  pass_done;

  // Row walk: one row read per cycle for the rectangle's rows.
  assign row_sum   = t + TIME_W'(k);
  assign raddr     = row_sum[ROW_W-1:0];
  assign rd_en     = ((st == ST_READ) || (st == ST_MARK)) && (k != dur);
  assign pass_done = (k == dur) && !rd_vld;

  // Write port: zero rows while clearing, read-modify-write while marking.
  assign mem_we = (st == ST_CLEAR) || ((st == ST_MARK) && rd_vld);
  assign waddr  = (st == ST_CLEAR) ? clr_addr : rd_addr_q;
  assign wdata  = (st == ST_CLEAR) ? '0 : (rdata | mask);

  // Request checks and search bounds.
  assign req_bad = (req.need == '0) || (req.dur == '0) || (req.need > req.usable) ||
                   ({1'b0, req.dur} > HORIZON_S[DUR_W:0]);
  assign t_end   = {1'b0, t} + SUM_W'(dur);
  assign s_end   = SUM_W'(s) + SUM_W'(need);
  assign base_mask = (need >= MAX_SL) ? '1 : ((MAX_SLICES'(1) << need) - MAX_SLICES'(1));

  assign req_ready = (st == ST_IDLE);

  // Occupancy grid.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata     <= mem[raddr];
      rd_addr_q <= raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= rd_en;
    end
  end

  // Search sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      case (st)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ROW_W'(1);
          if (clr_addr == ROW_W'(HORIZON - 1)) begin
            st <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req.valid) begin
            need   <= req.need;
            dur    <= req.dur;
            usable <= req.usable;
            t      <= req.level_start;
            if (req_bad) begin
              res_placed <= 1'b0;
              res_start  <= '0;
              res_slice  <= '0;
              res_end    <= '0;
              st         <= ST_DONE;
            end else begin
              st <= ST_TCHK;
            end
          end
        end
        ST_TCHK: begin
          if (t_end > HORIZON_S) begin
            res_placed <= 1'b0;
            res_start  <= '0;
            res_slice  <= '0;
            res_end    <= '0;
            st         <= ST_DONE;
          end else begin
            k    <= '0;
            busy <= '0;
            st   <= ST_READ;
          end
        end
        ST_READ: begin
          if (rd_en) begin
            k <= k + DUR_W'(1);
          end
          if (rd_vld) begin
            busy <= busy | rdata;
          end
          if (pass_done) begin
            s    <= '0;
            mask <= base_mask;
            st   <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (s_end > SUM_W'(usable)) begin
            t  <= t + TIME_W'(1);
            st <= ST_TCHK;
          end else if ((busy & mask) == '0) begin
            k  <= '0;
            st <= ST_MARK;
          end else begin
            s    <= s + SLICE_W'(1);
            mask <= mask << 1;
          end
        end
        ST_MARK: begin
          if (rd_en) begin
            k <= k + DUR_W'(1);
          end
          if (pass_done) begin
            res_placed <= 1'b1;
            res_start  <= t[START_W-1:0];
            res_slice  <= s + SLICE_W'(1);
            res_end    <= t_end[TIME_W-1:0];
            st         <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_take) begin
            st <= ST_IDLE;
          end
        end
        default: st <= ST_CLEAR;
      endcase
    end
  end

  assign res.valid       = (st == ST_DONE);
  assign res.placed      = res_placed;
  assign res.grant_time  = res_start;
  assign res.first_slice = res_slice;
  assign res.end_step    = res_end;

  // While the candidate span lies inside the usable slices, the scan mask covers exactly
  // the requested number of slices.
  `FFSTR_ASSERT_IMP(a_mask_width, clk, rst, (st == ST_SCAN) && (s_end <= SUM_W'(usable)),
                    $countones(mask) == int'(need))
  // A write never lands on the row being read in the same cycle.
  `FFSTR_ASSERT_IMP(a_no_rw_clash, clk, rst, mem_we && rd_en, waddr != raddr)
  // A placed rectangle ends inside the horizon and after its start.
  `FFSTR_ASSERT_IMP(a_end_in_range, clk, rst, (st == ST_DONE) && res_placed,
                    (SUM_W'(res_end) <= HORIZON_S) && (res_end > TIME_W'(res_start)))
  // The clearing pass ends in idle after its last row.
  `FFSTR_ASSERT_NXT(a_clear_end, clk, rst,
                    (st == ST_CLEAR) && (clr_addr == ROW_W'(HORIZON - 1)), st == ST_IDLE)
endmodule
`default_nettype wire

// File: rtl/core/first_fit_slice_time_reserver_unit.sv
// Top level of the first-fit slice/time reserver.
//
//   Channel  Handshake                 Word
//   in       in_valid / in_ready       slices_needed, duration, first_of_job, first_of_level
//   out      out_valid / out_ready     grant_time, first_slice, placed
//   cfg      cfg_we                    cfg_data (slices_in_use)
//
// After reset a clearing pass zeroes the 4096-row grid, one row a cycle; in_ready
// stays low until it ends.
// Per word: the idle state takes it, then for each candidate start time a bound check,
// a pass of row reads over its duration and a scan of candidate slice spans from the
// lowest upward; a fit adds a pass of row marking. The grid has a single read port and
// the compare unit tests one mask a cycle. One word is searched at a time; a finished
// word waits in done until the output register is free to take it.
`default_nettype none
module first_fit_slice_time_reserver_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [ffstr_pkg::SLICE_W-1:0]  cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [ffstr_pkg::SLICE_W-1:0]  slices_needed,
  input  wire logic [ffstr_pkg::DUR_W-1:0]    duration,
  input  wire logic                           first_of_job,
  input  wire logic                           first_of_level,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [ffstr_pkg::START_W-1:0]       grant_time,
  output logic [ffstr_pkg::SLICE_W-1:0]       first_slice,
  output logic                                placed
);
  import ffstr_pkg::*;

  logic [SLICE_W-1:0] slices_in_use;
  logic [TIME_W-1:0]  level_start;
  logic [TIME_W-1:0]  latest_end;
  logic [TIME_W-1:0]  level_start_next;
  logic [TIME_W-1:0]  latest_end_next;
  logic [SLICE_W-1:0] usable;
  logic               in_take;
  logic               res_take;
  ffstr_req_t         req;
  ffstr_res_t         res;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      slices_in_use <= SLICE_W'(50);
    end else if (cfg_we) begin
      slices_in_use <= cfg_data;
    end
  end

  assign usable = (slices_in_use > MAX_SL) ? MAX_SL : slices_in_use;

  // Level bookkeeping applied as a word is taken.
  assign latest_end_next  = first_of_job ? '0 : latest_end;
  assign level_start_next = first_of_level ? latest_end_next :
                            (first_of_job ? '0 : level_start);

  assign in_take = in_valid && in_ready;

  assign req.valid       = in_take;
  assign req.level_start = level_start_next;
  assign req.need        = slices_needed;
  assign req.dur         = duration;
  assign req.usable      = usable;

  assign res_take = !out_valid || out_ready;

  ffstr_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_ready (in_ready),
    .res       (res),
    .res_take  (res_take)
  );

  // Level start and latest end registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      level_start <= '0;
      latest_end  <= '0;
    end else if (in_take) begin
      level_start <= level_start_next;
      latest_end  <= latest_end_next;
    end else if (res.valid && res_take && res.placed && (res.end_step > latest_end)) begin
      latest_end <= res.end_step;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid && res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_take) begin
      grant_time  <= res.grant_time;
      first_slice <= res.first_slice;
      placed      <= res.placed;
    end
  end
endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the first-fit slice/time reserver with a built-in predictor.
`default_nettype none
module testbench;
  import ffstr_pkg::*;

  // A search whose cycle estimate exceeds this is redrawn, falling back to an empty one.
  localparam int unsigned SEARCH_BUDGET = 2500;
  localparam int unsigned NO_BUDGET     = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [SLICE_W-1:0] slices_needed;
    logic [DUR_W-1:0]   duration;
    logic               first_of_job;
    logic               first_of_level;
  } request_t;

  typedef struct packed {
    logic [START_W-1:0] grant_time;
    logic [SLICE_W-1:0] first_slice;
    logic               placed;
  } grant_t;

  // Scoreboard: keeps its own occupancy grid and level bookkeeping, and a queue of the
  // grants still owed by the block.
  class reservation_board;
    bit [MAX_SLICES-1:0] rows [HORIZON];
    int unsigned level_start;
    int unsigned latest_end;
    int unsigned slices_in_use;
    grant_t expected_grants [$];
    int unsigned errors;

    function new();
      level_start   = 0;
      latest_end    = 0;
      slices_in_use = 50;
      errors        = 0;
    endfunction

    // Works out the grant for one request. With commit set the grid and the level
    // bookkeeping take the request. The cycle estimate is an upper bound on the search
    // time and stops growing once it passes the budget.
    function grant_t place(request_t req, bit commit, int unsigned budget,
                           output int unsigned cycles);
      int unsigned lvl, last, usable, need, dur, t, k, s;
      bit [MAX_SLICES-1:0] busy, span;
      grant_t g;
      lvl  = level_start;
      last = latest_end;
      if (req.first_of_job) begin
        lvl  = 0;
        last = 0;
      end
      if (req.first_of_level) begin
        lvl = last;
      end
      if (commit) begin
        level_start = lvl;
        latest_end  = last;
      end
      g      = '0;
      cycles = 4;
      usable = (slices_in_use > MAX_SLICES) ? MAX_SLICES : slices_in_use;
      need   = req.slices_needed;
      dur    = req.duration;
      if (need == 0 || dur == 0 || need > usable || dur > HORIZON) begin
        return g;
      end
      // Scan start times upward; at each one take the lowest free span of slices.
      for (t = lvl; t + dur <= HORIZON && cycles <= budget; t++) begin
        busy = '0;
        for (k = 0; k < dur; k++) begin
          busy |= rows[t + k];
        end
        cycles += dur + slices_in_use + 4;
        for (s = 0; s + need <= usable; s++) begin
          span = '1;
          if (need < MAX_SLICES) begin
            span = ~(span << need);
          end
          span = span << s;
          if ((busy & span) == '0) begin
            cycles += dur + 8;
            if (commit) begin
              for (k = 0; k < dur; k++) begin
                rows[t + k] |= span;
              end
              if (t + dur > latest_end) begin
                latest_end = t + dur;
              end
            end
            g.placed      = 1'b1;
            g.grant_time  = START_W'(t);
            g.first_slice = SLICE_W'(s + 1);
            return g;
          end
        end
      end
      return g;
    endfunction

    // Records an accepted request and queues the grant it must produce.
    function void note_request(request_t req);
      int unsigned cycles;
      grant_t g;
      g = place(req, 1'b1, NO_BUDGET, cycles);
      expected_grants.insert(expected_grants.size(), g);
    endfunction

    function void report(string field, int unsigned want, int unsigned got);
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    // Compares one accepted result word with the oldest expected grant.
    function void check_result(grant_t got);
      grant_t want;
      if (expected_grants.size() == 0) begin
        errors++;
        $display("%0t: result word with none expected, expected none, actual %0d/%0d/%0d",
                 $time, got.grant_time, got.first_slice, got.placed);
        return;
      end
      want = expected_grants.pop_front();
      if (got.grant_time !== want.grant_time) begin
        report("grant_time", want.grant_time, got.grant_time);
      end
      if (got.first_slice !== want.first_slice) begin
        report("first_slice", want.first_slice, got.first_slice);
      end
      if (got.placed !== want.placed) begin
        report("placed", want.placed, got.placed);
      end
    endfunction
  endclass

  logic               clk            = 1'b0;
  logic               rst            = 1'b1;
  logic               cfg_we         = 1'b0;
  logic [SLICE_W-1:0] cfg_data       = '0;
  logic               in_valid       = 1'b0;
  logic               in_ready;
  logic [SLICE_W-1:0] slices_needed  = '0;
  logic [DUR_W-1:0]   duration       = '0;
  logic               first_of_job   = 1'b0;
  logic               first_of_level = 1'b0;
  logic               out_valid;
  logic               out_ready      = 1'b0;
  logic [START_W-1:0] grant_time;
  logic [SLICE_W-1:0] first_slice;
  logic               placed;

  reservation_board board = new();

  first_fit_slice_time_reserver_unit dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .slices_needed  (slices_needed),
    .duration       (duration),
    .first_of_job   (first_of_job),
    .first_of_level (first_of_level),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .grant_time     (grant_time),
    .first_slice    (first_slice),
    .placed         (placed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: check each accepted word, stall on a changing pattern, and hold off
  // once for a long stretch so that the block backs up into its input.
  int unsigned words_taken  = 0;
  int unsigned hold_left    = 0;
  int unsigned pattern_age  = 0;
  logic [15:0] stall_pattern = '0;
  logic [3:0]  pattern_pos   = '0;
  bit          hold_done     = 1'b0;

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        board.check_result({grant_time, first_slice, placed});
        words_taken++;
      end
      if (pattern_age == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pattern <= '0;
          1: stall_pattern <= 16'($urandom);
          2: stall_pattern <= 16'($urandom | $urandom);
          default: stall_pattern <= 16'($urandom & $urandom & $urandom);
        endcase
        pattern_age <= $urandom_range(16, 96);
      end else begin
        pattern_age <= pattern_age - 1;
      end
      pattern_pos <= pattern_pos + 1'b1;
      if (!hold_done && words_taken >= 80) begin
        hold_done <= 1'b1;
        hold_left <= 600;
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !stall_pattern[pattern_pos];
      end
    end
  end

  // Request side: bursts of random length separated by random gaps.
  int unsigned burst_left = 0;

  task automatic offer(input request_t req);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid       <= 1'b1;
    slices_needed  <= req.slices_needed;
    duration       <= req.duration;
    first_of_job   <= req.first_of_job;
    first_of_level <= req.first_of_level;
    do @(posedge clk); while (!in_ready);
    board.note_request(req);
    burst_left--;
  endtask

  function automatic request_t request_of(int unsigned need, int unsigned dur,
                                          bit new_job, bit new_level);
    request_t req;
    req.slices_needed  = SLICE_W'(need);
    req.duration       = DUR_W'(dur);
    req.first_of_job   = new_job;
    req.first_of_level = new_level;
    return req;
  endfunction

  // Mostly small well-formed requests, with some wide, long, empty and oversized ones.
  function automatic request_t random_request(int unsigned usable, bit new_job);
    request_t req;
    int unsigned roll, top;
    top  = (usable == 0) ? 1 : usable;
    roll = $urandom_range(0, 99);
    if (roll < 80) begin
      req.slices_needed = SLICE_W'($urandom_range(1, (top < 12) ? top : 12));
    end else if (roll < 92) begin
      req.slices_needed = SLICE_W'($urandom_range(1, top));
    end else if (roll < 95) begin
      req.slices_needed = '0;
    end else begin
      req.slices_needed = SLICE_W'($urandom_range(0, 127));
    end
    roll = $urandom_range(0, 99);
    if (roll < 72) begin
      req.duration = DUR_W'($urandom_range(1, 16));
    end else if (roll < 86) begin
      req.duration = DUR_W'($urandom_range(1, 64));
    end else if (roll < 93) begin
      req.duration = DUR_W'($urandom_range(1, 400));
    end else if (roll < 95) begin
      req.duration = '0;
    end else if (roll < 97) begin
      req.duration = DUR_W'($urandom_range(HORIZON + 1, 8191));
    end else begin
      req.duration = DUR_W'($urandom_range(1, HORIZON));
    end
    req.first_of_job   = new_job || ($urandom_range(0, 149) == 0);
    req.first_of_level = ($urandom_range(0, 5) == 0);
    return req;
  endfunction

  // Draws requests until one has a bounded search; otherwise falls back to an empty one.
  function automatic request_t budgeted_request(int unsigned usable, bit new_job);
    request_t req;
    int unsigned cycles, tries;
    for (tries = 0; tries < 8; tries++) begin
      req = random_request(usable, new_job);
      void'(board.place(req, 1'b0, SEARCH_BUDGET, cycles));
      if (cycles <= SEARCH_BUDGET) begin
        return req;
      end
    end
    req.duration = '0;
    return req;
  endfunction

  task automatic run_requests(input int unsigned count);
    int unsigned usable, n;
    usable = (board.slices_in_use > MAX_SLICES) ? MAX_SLICES : board.slices_in_use;
    for (n = 0; n < count; n++) begin
      offer(budgeted_request(usable, n == 0));
    end
  endtask

  // Register writes wait until every owed grant has come back and the block is quiet.
  task automatic write_slices(input logic [SLICE_W-1:0] value);
    in_valid <= 1'b0;
    while (board.expected_grants.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.slices_in_use = value;
  endtask

  initial begin
    request_t opening [$];
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    // Opening sequence at the reset slice count: a long reservation pushes the level
    // to the horizon, then come the horizon cases, the level and job restarts, and the
    // empty, oversized and too-wide requests.
    opening = '{
      request_of(49, 1, 1'b1, 1'b0),
      request_of(1, 4000, 1'b0, 1'b0),
      request_of(1, 100, 1'b0, 1'b1),
      request_of(1, 50, 1'b0, 1'b0),
      request_of(50, 46, 1'b0, 1'b1),
      request_of(1, 1, 1'b0, 1'b0),
      request_of(1, 4095, 1'b0, 1'b0),
      request_of(2, 3, 1'b1, 1'b1),
      request_of(2, 3, 1'b0, 1'b0),
      request_of(5, 2, 1'b0, 1'b0),
      request_of(3, 2, 1'b0, 1'b1),
      request_of(49, 1, 1'b0, 1'b0),
      request_of(51, 1, 1'b0, 1'b0),
      request_of(64, 1, 1'b0, 1'b0),
      request_of(0, 5, 1'b0, 1'b0),
      request_of(3, 0, 1'b0, 1'b0),
      request_of(127, 8191, 1'b0, 1'b0),
      request_of(4, 4097, 1'b0, 1'b0),
      request_of(49, 4096, 1'b1, 1'b0),
      request_of(1, 1, 1'b1, 1'b1)
    };
    foreach (opening[i]) begin
      offer(opening[i]);
    end
    run_requests(330);
    // Slice counts at the top, above the limit, the bottom, zero, and one in between.
    write_slices(SLICE_W'(MAX_SLICES));
    run_requests(240);
    write_slices(SLICE_W'(127));
    run_requests(200);
    write_slices(SLICE_W'(1));
    run_requests(150);
    write_slices(SLICE_W'(0));
    run_requests(40);
    write_slices(SLICE_W'($urandom_range(2, MAX_SLICES - 1)));
    run_requests(220);
    in_valid <= 1'b0;
    while (board.expected_grants.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.errors == 0 && board.expected_grants.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Watchdog for a block that stops answering.
  initial begin
    #150_000_000;
    $display("testbench: done, errors");
    $finish;
  end
endmodule
`default_nettype wire

// File: sim.f
+incdir+rtl/core
rtl/core/ffstr_pkg.sv
rtl/core/ffstr_engine.sv
rtl/core/first_fit_slice_time_reserver_unit.sv
tb/sv/testbench.sv
